@@ hw/rtl/sokrp_pkg.sv @@
// Shared types and constants of the omega-k reference phasor block.
// Used by sokrp_isqrt and sar_omega_k_reference_phasor.
`timescale 1ns / 1ps
`default_nettype none

package sokrp_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CARRIER,
		REG_DOPPLER,
		REG_RANGE,
		REG_CHIRP
	} reg_idx_t;

	localparam int CARRIER_W = 44;
	localparam int DOPPLER_W = 56;
	localparam int RANGE_W   = 48;
	localparam int CHIRP_W   = 64;

	// latency of sokrp_mul
	localparam int MUL_LAT = 4;

	// radicand bit pairs; the radicand is below 2^106
	localparam int SQRT_PAIRS = 53;

	// floor(2^64 / (2 pi))
	localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

	// gain-compensated start vector, Q2.30
	localparam logic signed [33:0] CORDIC_START = 34'sd652032875;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81,
		32'd41, 32'd20, 32'd10, 32'd5,
		32'd3, 32'd1, 32'd1, 32'd0
	};

endpackage

`default_nettype wire

@@ hw/rtl/sar_omega_k_reference_phasor.sv @@
// Omega-k reference phasor: top level with configuration registers and the full pipeline.
// Depends on sokrp_pkg, sokrp_mul and sokrp_isqrt.
`timescale 1ns / 1ps
`default_nettype none

// Takes one grid point (doppler_freq, range_freq) per cycle and returns the unit phasor
// of theta = range_scale*sqrt(max(0,(f0+fr)^2 - doppler_coeff*fa^2)) + chirp_coeff*fr^2
// as Q1.15 cos/sin, with last_point passed along. Most of the pipeline is the 53-stage
// square root, then two multipliers in a row and one stage per CORDIC iteration. A new
// point is accepted every cycle; a stall on the output freezes the whole pipeline.
// Registers sit at byte addresses 0, 8, 16, 24 and should only be written while no points
// are in flight. There is no start-up clearing; the block is ready right after reset.
module sar_omega_k_reference_phasor #(
	parameter int CORDIC_STEPS = 16,
	parameter int PHASE_BITS   = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// apb configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [63:0]        pwdata,
	output logic      [63:0]        prdata,
	output logic                    pready,
	// grid point
	input  wire logic               point_valid,
	output logic                    point_ready,
	input  wire logic signed [31:0] doppler_freq,
	input  wire logic signed [39:0] range_freq,
	input  wire logic               last_point,
	// phasor
	output logic                    phasor_valid,
	input  wire logic               phasor_ready,
	output logic signed [15:0]      cos_part,
	output logic signed [15:0]      sin_part,
	output logic                    last_out
);

	localparam int ML      = sokrp_pkg::MUL_LAT;
	localparam int ST_RAD  = 10;
	localparam int ST_ROOT = ST_RAD + sokrp_pkg::SQRT_PAIRS;
	localparam int ST_T1   = ST_ROOT + 2 * ML;
	localparam int ST_FRD  = ST_T1 - 1 - 3 * ML;
	localparam int ST_ANG  = ST_T1 + 1;
	localparam int ST_MAP  = ST_ANG + CORDIC_STEPS + 1;
	localparam int LAST    = ST_MAP + 1;
	localparam int ANG_TOP = (PHASE_BITS < 32) ? PHASE_BITS : 32;

	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} quad_t;

	// configuration registers
	logic [sokrp_pkg::CARRIER_W-1:0] carrier_freq_q;
	logic [sokrp_pkg::DOPPLER_W-1:0] doppler_coeff_q;
	logic [sokrp_pkg::RANGE_W-1:0]   range_scale_q;
	logic [sokrp_pkg::CHIRP_W-1:0]   chirp_coeff_q;
	logic [63:0]                     chirp_mag_q;
	logic                            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_freq_q  <= '0;
			doppler_coeff_q <= '0;
			range_scale_q   <= '0;
			chirp_coeff_q   <= '0;
			chirp_mag_q     <= '0;
		end else begin
			chirp_mag_q <= chirp_coeff_q[63] ? (~chirp_coeff_q + 64'd1) : chirp_coeff_q;
			if (cfg_wr) begin
				case (sokrp_pkg::reg_idx_t'(paddr[4:3]))
					sokrp_pkg::REG_CARRIER: carrier_freq_q  <= pwdata[sokrp_pkg::CARRIER_W-1:0];
					sokrp_pkg::REG_DOPPLER: doppler_coeff_q <= pwdata[sokrp_pkg::DOPPLER_W-1:0];
					sokrp_pkg::REG_RANGE:   range_scale_q   <= pwdata[sokrp_pkg::RANGE_W-1:0];
					sokrp_pkg::REG_CHIRP:   chirp_coeff_q   <= pwdata;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (sokrp_pkg::reg_idx_t'(paddr[4:3]))
			sokrp_pkg::REG_CARRIER: prdata = 64'(carrier_freq_q);
			sokrp_pkg::REG_DOPPLER: prdata = 64'(doppler_coeff_q);
			sokrp_pkg::REG_RANGE:   prdata = 64'(range_scale_q);
			sokrp_pkg::REG_CHIRP:   prdata = chirp_coeff_q;
			default:                prdata = '0;
		endcase
	end

	// whole pipeline moves together
	logic adv;
	logic vld_s  [1:LAST];
	logic last_s [1:LAST];

	assign adv          = ~phasor_valid | phasor_ready;
	assign point_ready  = adv;
	assign phasor_valid = vld_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= point_valid;
			for (int k = 2; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s[1] <= last_point;
			for (int k = 2; k <= LAST; k++) begin
				last_s[k] <= last_s[k-1];
			end
		end
	end

	// input magnitudes and f0 + fr
	logic [31:0] fa_mag_s1;
	logic [45:0] fsum_s1;
	logic [44:0] fsum_mag_s2;
	logic [39:0] fr_mag_s [1:ST_FRD];

	always_ff @(posedge clk) begin
		if (adv) begin
			fa_mag_s1   <= doppler_freq[31] ? 32'(-doppler_freq) : 32'(doppler_freq);
			fr_mag_s[1] <= range_freq[39] ? 40'(-range_freq) : 40'(range_freq);
			fsum_s1     <= {2'b00, carrier_freq_q} + {{6{range_freq[39]}}, range_freq};
			fsum_mag_s2 <= fsum_s1[45] ? 45'(~fsum_s1 + 46'd1) : fsum_s1[44:0];
			for (int k = 2; k <= ST_FRD; k++) begin
				fr_mag_s[k] <= fr_mag_s[k-1];
			end
		end
	end

	// radicand
	logic [63:0]  fa2_s5;
	logic [89:0]  fs2_s6;
	logic [89:0]  fs2_s7;
	logic [89:0]  fs2_s8;
	logic [89:0]  fs2_s9;
	logic [118:0] fterm_s9;
	logic [119:0] rdiff;
	logic [2*sokrp_pkg::SQRT_PAIRS-1:0] rad_s10;

	sokrp_mul #(.AW(32), .BW(32), .PW(64)) u_fa2 (
		.clk(clk), .en(adv), .a(fa_mag_s1), .b(fa_mag_s1), .p(fa2_s5)
	);

	sokrp_mul #(.AW(45), .BW(45), .PW(90)) u_fs2 (
		.clk(clk), .en(adv), .a(fsum_mag_s2), .b(fsum_mag_s2), .p(fs2_s6)
	);

	sokrp_mul #(.AW(63), .BW(56), .PW(119)) u_fterm (
		.clk(clk), .en(adv), .a(fa2_s5[62:0]), .b(doppler_coeff_q), .p(fterm_s9)
	);

	// negative radicand clamps to zero
	assign rdiff = {14'b0, fs2_s9, 16'b0} - {1'b0, fterm_s9};

	always_ff @(posedge clk) begin
		if (adv) begin
			fs2_s7  <= fs2_s6;
			fs2_s8  <= fs2_s7;
			fs2_s9  <= fs2_s8;
			rad_s10 <= rdiff[119] ? '0 : rdiff[2*sokrp_pkg::SQRT_PAIRS-1:0];
		end
	end

	logic [sokrp_pkg::SQRT_PAIRS-1:0] root_s63;

	sokrp_isqrt u_isqrt (
		.clk(clk), .en(adv), .rad(rad_s10), .root(root_s63)
	);

	// range term in units of 2^-128 turn
	logic [100:0] prod_s67;
	logic [127:0] t1_s71;

	sokrp_mul #(.AW(sokrp_pkg::SQRT_PAIRS), .BW(48), .PW(101)) u_prod (
		.clk(clk), .en(adv), .a(root_s63), .b(range_scale_q), .p(prod_s67)
	);

	sokrp_mul #(.AW(101), .BW(64), .PW(128)) u_t1 (
		.clk(clk), .en(adv), .a(prod_s67), .b(sokrp_pkg::INV_TWO_PI), .p(t1_s71)
	);

	// chirp term, timed to land with the range term
	logic [79:0]  fr2_s62;
	logic [143:0] m_s66;
	logic [127:0] t2_s70;
	logic [127:0] t2_s71;

	sokrp_mul #(.AW(40), .BW(40), .PW(80)) u_fr2 (
		.clk(clk), .en(adv), .a(fr_mag_s[ST_FRD]), .b(fr_mag_s[ST_FRD]), .p(fr2_s62)
	);

	sokrp_mul #(.AW(64), .BW(80), .PW(144)) u_m (
		.clk(clk), .en(adv), .a(chirp_mag_q), .b(fr2_s62), .p(m_s66)
	);

	sokrp_mul #(.AW(128), .BW(64), .PW(128)) u_t2 (
		.clk(clk), .en(adv), .a(m_s66[143:16]), .b(sokrp_pkg::INV_TWO_PI), .p(t2_s70)
	);

	logic [127:0] tot;
	logic [31:0]  ang_s72;

	assign tot = t1_s71 + t2_s71;

	always_ff @(posedge clk) begin
		if (adv) begin
			t2_s71  <= chirp_coeff_q[63] ? (~t2_s70 + 128'd1) : t2_s70;
			ang_s72 <= 32'(tot[127 -: ANG_TOP]) << (32 - ANG_TOP);
		end
	end

	// cordic, one iteration per stage, on the first quadrant
	logic signed [33:0] cx_s [CORDIC_STEPS];
	logic signed [33:0] cy_s [CORDIC_STEPS];
	logic signed [33:0] cz_s [CORDIC_STEPS];
	logic        [1:0]  cq_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [33:0] x_in;
		logic signed [33:0] y_in;
		logic signed [33:0] z_in;
		logic        [1:0]  q_in;
		logic signed [33:0] at;

		if (i == 0) begin : g_first
			assign x_in = sokrp_pkg::CORDIC_START;
			assign y_in = '0;
			assign z_in = $signed({4'b0000, ang_s72[29:0]});
			assign q_in = ang_s72[31:30];
		end else begin : g_next
			assign x_in = cx_s[i-1];
			assign y_in = cy_s[i-1];
			assign z_in = cz_s[i-1];
			assign q_in = cq_s[i-1];
		end

		assign at = $signed({2'b00, sokrp_pkg::ATAN_TURN[i]});

		always_ff @(posedge clk) begin
			if (adv) begin
				cq_s[i] <= q_in;
				if (!z_in[33]) begin
					cx_s[i] <= x_in - (y_in >>> i);
					cy_s[i] <= y_in + (x_in >>> i);
					cz_s[i] <= z_in - at;
				end else begin
					cx_s[i] <= x_in + (y_in >>> i);
					cy_s[i] <= y_in - (x_in >>> i);
					cz_s[i] <= z_in + at;
				end
			end
		end
	end

	// quadrant fold-back
	logic signed [34:0] xe;
	logic signed [34:0] ye;
	logic signed [34:0] cos_sm;
	logic signed [34:0] sin_sm;

	assign xe = 35'(cx_s[CORDIC_STEPS-1]);
	assign ye = 35'(cy_s[CORDIC_STEPS-1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			case (quad_t'(cq_s[CORDIC_STEPS-1]))
				QUAD_I: begin
					cos_sm <= xe;
					sin_sm <= ye;
				end
				QUAD_II: begin
					cos_sm <= -ye;
					sin_sm <= xe;
				end
				QUAD_III: begin
					cos_sm <= -xe;
					sin_sm <= -ye;
				end
				default: begin
					cos_sm <= ye;
					sin_sm <= -xe;
				end
			endcase
		end
	end

	// round half up to q1.15 and saturate
	function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
		logic signed [35:0] t;
		logic signed [20:0] q;
		t = 36'(v) + 36'sd16384;
		q = 21'(t >>> 15);
		if (q > 21'sd32767) begin
			return 16'sd32767;
		end else if (q < -21'sd32768) begin
			return -16'sd32768;
		end else begin
			return q[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_part <= to_q15(cos_sm);
			sin_part <= to_q15(sin_sm);
		end
	end

	assign last_out = last_s[LAST];

endmodule

`default_nettype wire

@@ hw/rtl/sokrp_mul.sv @@
// Pipelined unsigned multiplier built from 32x32 partial products.
// Result is the product modulo 2^PW, registered through the pp_s1, row_s2, pair_s3 and p stages.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module sokrp_mul #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int PW = 64
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] a,
	input  wire logic [BW-1:0] b,
	output logic      [PW-1:0] p
);

	localparam int NP  = ((AW + 31) / 32 + 1) / 2;
	localparam int NA  = 2 * NP;
	localparam int NB  = (BW + 31) / 32;
	localparam int AXW = NA * 32;
	localparam int BXW = NB * 32;

	logic [AXW-1:0] a_ext;
	logic [BXW-1:0] b_ext;
	logic [63:0]    pp_s1 [NA][NB];
	logic [PW-1:0]  row_c [NA];
	logic [PW-1:0]  row_s2 [NA];
	logic [PW-1:0]  pair_c [NP];
	logic [PW-1:0]  pair_s3 [NP];

	assign a_ext = AXW'(a);
	assign b_ext = BXW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= {32'b0, a_ext[32*i +: 32]} * {32'b0, b_ext[32*j +: 32]};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (PW'(pp_s1[i][j]) << (32 * (i + j)));
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NP; k++) begin
			pair_c[k] = row_s2[2*k] + row_s2[2*k+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2  <= row_c;
			pair_s3 <= pair_c;
		end
	end

	logic [PW-1:0] fin_c;
	always_comb begin
		fin_c = '0;
		for (int k = 0; k < NP; k++) begin
			fin_c = fin_c + pair_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= fin_c;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/sokrp_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on sokrp_pkg for the radicand size.
`timescale 1ns / 1ps
`default_nettype none

module sokrp_isqrt (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic [2*sokrp_pkg::SQRT_PAIRS-1:0]   rad,
	output logic      [sokrp_pkg::SQRT_PAIRS-1:0]     root
);

	localparam int P     = sokrp_pkg::SQRT_PAIRS;
	localparam int REM_W = P + 3;

	logic [REM_W-1:0] rem_s  [P];
	logic [P-1:0]     root_s [P];
	logic [2*P-1:0]   rad_s  [P];

	for (genvar k = 0; k < P; k++) begin : g_step
		logic [REM_W-1:0] rem_in;
		logic [P-1:0]     root_in;
		logic [2*P-1:0]   rad_in;
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		// bring down the next pair and try root*4+1
		assign cur   = {rem_in[REM_W-3:0], rad_in[2*P-1 -: 2]};
		assign trial = REM_W'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= {rad_in[2*P-3:0], 2'b00};
				if (cur >= trial) begin
					rem_s[k]  <= cur - trial;
					root_s[k] <= {root_in[P-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cur;
					root_s[k] <= {root_in[P-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[P-1];

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for sar_omega_k_reference_phasor: a bit-exact phase/CORDIC predictor,
// a queue-based scoreboard, an APB register driver and random handshake idling.
// Depends on sokrp_pkg and the block's RTL.
`timescale 1ns / 1ps

typedef struct {
	logic signed [15:0] cos_v;
	logic signed [15:0] sin_v;
	logic               last_v;
} phasor_t;

class phasor_scoreboard;
	logic [43:0] f0;
	logic [55:0] dop;
	logic [47:0] rscale;
	logic [63:0] chirp;
	phasor_t     pending_q[$];
	int          errors;
	int          checked;

	function new();
		f0 = '0; dop = '0; rscale = '0; chirp = '0;
		errors = 0; checked = 0;
	endfunction

	function void set_reg(sokrp_pkg::reg_idx_t idx, logic [63:0] v);
		case (idx)
			sokrp_pkg::REG_CARRIER: f0 = v[43:0];
			sokrp_pkg::REG_DOPPLER: dop = v[55:0];
			sokrp_pkg::REG_RANGE:   rscale = v[47:0];
			sokrp_pkg::REG_CHIRP:   chirp = v;
			default: ;
		endcase
	endfunction

	function logic signed [15:0] round_q15(logic signed [63:0] v);
		logic signed [63:0] q;
		q = (v + 64'sd16384) >>> 15;
		if (q > 64'sd32767) q = 64'sd32767;
		if (q < -64'sd32768) q = -64'sd32768;
		return q[15:0];
	endfunction

	function phasor_t compute_phasor(logic signed [31:0] fa, logic signed [39:0] fr,
			logic lst);
		logic [127:0] fa_m, fr_m, fsm, fs2, fterm, rad, root, c, t1, t2, m2, tot;
		logic [127:0] inv;
		logic [191:0] prod;
		logic signed [63:0] fsum, x, y, z, nx, ny, cc, ss;
		logic [63:0] cm;
		logic [31:0] ang;
		logic [1:0] quad;
		phasor_t r;
		inv = {64'b0, sokrp_pkg::INV_TWO_PI};
		fa_m = fa[31] ? 128'(-$signed({fa[31], fa})) : 128'({1'b0, fa});
		fr_m = fr[39] ? 128'(-$signed({fr[39], fr})) : 128'({1'b0, fr});
		fsum = fr[39] ? $signed({20'b0, f0}) - $signed(fr_m[63:0])
			: $signed({20'b0, f0}) + $signed(fr_m[63:0]);
		fsm = fsum < 0 ? 128'(-fsum) : 128'(fsum);
		fs2 = (fsm * fsm) << 16;
		fterm = fa_m * fa_m * {72'b0, dop};
		rad = (fs2 >= fterm) ? fs2 - fterm : '0;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			c = root | (128'd1 << b);
			if (c * c <= rad) root = c;
		end
		t1 = {80'b0, rscale} * root * inv;
		cm = chirp[63] ? -chirp : chirp;
		prod = {128'b0, cm} * {64'b0, fr_m * fr_m};
		m2 = prod[143:16];
		t2 = m2 * inv;
		if (chirp[63]) t2 = -t2;
		tot = t1 + t2;
		ang = tot[127:96];
		quad = ang[31:30];
		z = {34'b0, ang[29:0]};
		x = 64'(sokrp_pkg::CORDIC_START);
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - $signed({32'b0, sokrp_pkg::ATAN_TURN[i]});
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + $signed({32'b0, sokrp_pkg::ATAN_TURN[i]});
			end
			x = nx;
			y = ny;
		end
		case (quad)
			2'd0: begin cc = x; ss = y; end
			2'd1: begin cc = -y; ss = x; end
			2'd2: begin cc = -x; ss = -y; end
			default: begin cc = y; ss = -x; end
		endcase
		r.cos_v = round_q15(cc);
		r.sin_v = round_q15(ss);
		r.last_v = lst;
		return r;
	endfunction

	function void note_point(logic signed [31:0] fa, logic signed [39:0] fr, logic lst);
		pending_q.push_back(compute_phasor(fa, fr, lst));
	endfunction

	function void check_phasor(logic signed [15:0] cv, logic signed [15:0] sv, logic lv);
		phasor_t e;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected phasor cos=%0d sin=%0d last=%0d", $time, cv, sv, lv);
			errors++;
			return;
		end
		e = pending_q.pop_front();
		checked++;
		if (cv !== e.cos_v) begin
			$display("%0t: cos_part expected %0d got %0d", $time, e.cos_v, cv);
			errors++;
		end
		if (sv !== e.sin_v) begin
			$display("%0t: sin_part expected %0d got %0d", $time, e.sin_v, sv);
			errors++;
		end
		if (lv !== e.last_v) begin
			$display("%0t: last_out expected %0d got %0d", $time, e.last_v, lv);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0, penable = 0, pwrite = 0;
	logic [4:0]         paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;
	logic               point_valid = 0;
	logic               point_ready;
	logic signed [31:0] doppler_freq = '0;
	logic signed [39:0] range_freq = '0;
	logic               last_point = 0;
	logic               phasor_valid;
	logic               phasor_ready = 0;
	logic signed [15:0] cos_part, sin_part;
	logic               last_out;

	phasor_scoreboard sb = new();
	logic calm = 0;
	logic hold_req = 0;
	int   n_points = 0;
	int   n_cfg = 0;

	sar_omega_k_reference_phasor uut (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#5ms;
		$display("timeout with %0d phasors outstanding", sb.pending_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && point_valid && point_ready)
			sb.note_point(doppler_freq, range_freq, last_point);
		if (arst_n && phasor_valid && phasor_ready)
			sb.check_phasor(cos_part, sin_part, last_out);
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				phasor_ready = 0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				phasor_ready = 0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				phasor_ready = 1;
			end
		end
	end

	task automatic write_reg(sokrp_pkg::reg_idx_t idx, logic [63:0] v);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = 5'(int'(idx) * 8); pwdata = v;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		sb.set_reg(idx, v);
		n_cfg++;
	endtask

	// called at a falling edge; returns at a falling edge after acceptance and any random idling
	task automatic send_point(logic signed [31:0] fa, logic signed [39:0] fr, logic lst);
		point_valid = 1;
		doppler_freq = fa;
		range_freq = fr;
		last_point = lst;
		do @(posedge clk); while (!point_ready);
		@(negedge clk);
		n_points++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			point_valid = 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	task automatic drain();
		point_valid = 0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic random_points(int n);
		logic signed [31:0] fa;
		logic signed [39:0] fr;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) < 4) begin
				fa = $signed(32'($urandom_range(0, 2097151))) - 32'sd1048576;
				fr = $signed(40'({$urandom_range(0, 255), $urandom})) - 40'sd68719476736;
			end else begin
				fa = $urandom;
				fr = {8'($urandom), 32'($urandom)};
			end
			send_point(fa, fr, 1'($urandom));
		end
	endtask

	task automatic config_all(logic [63:0] a, logic [63:0] b, logic [63:0] c,
			logic [63:0] d);
		write_reg(sokrp_pkg::REG_CARRIER, a);
		write_reg(sokrp_pkg::REG_DOPPLER, b);
		write_reg(sokrp_pkg::REG_RANGE, c);
		write_reg(sokrp_pkg::REG_CHIRP, d);
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// all registers zero: theta is zero, cosine saturates at full scale
		send_point(32'sd0, 40'sd0, 1'b0);
		send_point(32'sh7FFFFFFF, 40'sh7FFFFFFFFF, 1'b1);
		send_point(32'sh80000000, 40'sh8000000000, 1'b0);
		drain();
		// realistic x-band setup
		config_all(64'd2457600000000, 64'h0000_2A00_0000_0000, 64'h0000_0123_4567_89AB,
			64'hFFFF_FFF0_0000_0000);
		send_point(32'sd0, 40'sd0, 1'b1);
		send_point(32'sd25600, 40'sd0, 1'b0);
		send_point(32'sh7FFFFFFF, 40'sd0, 1'b0);     // negative radicand
		send_point(32'sh80000000, 40'sd0, 1'b1);
		send_point(32'sd0, 40'sh7FFFFFFFFF, 1'b0);
		send_point(32'sd0, 40'sh8000000000, 1'b1);
		send_point(32'sh80000000, 40'sh8000000000, 1'b0);
		send_point(32'sh7FFFFFFF, 40'sh7FFFFFFFFF, 1'b1);
		send_point(-32'sd25600, -40'sd1000000000, 1'b0);
		send_point(32'sd1, -40'sd1, 1'b1);
		random_points(120);
		hold_req = 1;
		random_points(160);
		drain();
		// top of every register, most negative chirp
		config_all('1, '1, '1, 64'h8000_0000_0000_0000);
		random_points(280);
		drain();
		// positive chirp, small doppler coefficient
		config_all({$urandom, $urandom}, 64'd65536, {$urandom, $urandom},
			64'h7FFF_FFFF_FFFF_FFFF);
		random_points(280);
		drain();
		config_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		random_points(280);
		drain();
		config_all(64'd1000000000000, 64'h0000_0001_0000_0000, {$urandom, $urandom},
			{$urandom, $urandom});
		random_points(280);
		drain();
		// closing stretch without idling
		calm = 1;
		config_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		random_points(300);
		drain();
		$display("covered %0d grid points and %0d register writes over seven setups",
			n_points, n_cfg);
		$display("%0d phasors checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
